>>> rtl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Code unit ranges
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;

    // UTF-8 encoding limits and lead bytes
    localparam logic [20:0] MAX_1B     = 21'h00007F;
    localparam logic [20:0] MAX_2B     = 21'h0007FF;
    localparam logic [20:0] MAX_3B     = 21'h00FFFF;
    localparam logic [7:0]  LEAD_2B    = 8'hC0;
    localparam logic [7:0]  LEAD_3B    = 8'hE0;
    localparam logic [7:0]  LEAD_4B    = 8'hF0;
    localparam logic [7:0]  CONT_BYTE  = 8'h80;

    // Byte mode filter
    localparam logic [7:0] PRINT_MIN = 8'h20;
    localparam logic [7:0] DEL_CHAR  = 8'h7F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_end;
    } t_out_item;

    // One queued command: an optional flushed high surrogate, then an
    // optional main code point or raw byte. At least one part is present.
    typedef struct packed {
        logic        has_held;
        logic [9:0]  held_bits;
        logic        has_main;
        logic        main_raw;
        logic [20:0] main_cp;
    } t_cmd;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= MAX_1B) begin
            len = 3'd1;
        end else if (cp <= MAX_2B) begin
            len = 3'd2;
        end else if (cp <= MAX_3B) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [2:0]  len,
                                             input logic [1:0]  idx);
        logic [7:0] b;
        b = cp[7:0];
        unique case (len)
            3'd2: begin
                b = (idx == 2'd0) ? (LEAD_2B | {3'b000, cp[10:6]})
                                  : (CONT_BYTE | {2'b00, cp[5:0]});
            end
            3'd3: begin
                case (idx)
                    2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (idx)
                    2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/u16u8_front.sv
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_in,
    output logic          o_full,
    input  wire logic     i_cfg_valid,
    input  wire logic     i_cfg_wide_mode,
    output logic          o_cmd_push,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_full
);

    logic       r_wide_mode, n_wide_mode;
    logic       r_odd_phase, n_odd_phase;
    logic [7:0] r_first_half, n_first_half;
    logic       r_held, n_held;
    logic [9:0] r_held_bits, n_held_bits;

    logic        accept;
    logic [15:0] unit;
    logic        unit_is_high;
    logic        unit_is_low;
    t_cmd        cmd;

    assign accept       = i_push && !i_cmd_full;
    assign unit         = {r_first_half, i_in.in_byte};
    assign unit_is_high = (unit >= SURR_HI_MIN) && (unit <= SURR_HI_MAX);
    assign unit_is_low  = (unit >= SURR_LO_MIN) && (unit <= SURR_LO_MAX);

    always_comb begin
        n_wide_mode  = i_cfg_valid ? i_cfg_wide_mode : r_wide_mode;
        n_odd_phase  = r_odd_phase;
        n_first_half = r_first_half;
        n_held       = r_held;
        n_held_bits  = r_held_bits;
        cmd          = '0;
        if (accept) begin
            if (!r_wide_mode) begin
                if ((i_in.in_byte >= PRINT_MIN) && (i_in.in_byte != DEL_CHAR)) begin
                    cmd.has_main = 1'b1;
                    cmd.main_raw = 1'b1;
                    cmd.main_cp  = {13'd0, i_in.in_byte};
                end
            end else if (!r_odd_phase) begin
                n_first_half = i_in.in_byte;
                n_odd_phase  = 1'b1;
                if (i_in.in_final) begin
                    cmd.has_held  = r_held;
                    cmd.held_bits = r_held_bits;
                end
            end else begin
                n_odd_phase  = 1'b0;
                n_first_half = '0;
                n_held       = 1'b0;
                n_held_bits  = '0;
                if (r_held && unit_is_low) begin
                    cmd.has_main = 1'b1;
                    cmd.main_cp  = SUPP_BASE + {1'b0, r_held_bits, unit[9:0]};
                end else begin
                    cmd.has_held  = r_held;
                    cmd.held_bits = r_held_bits;
                    if (unit_is_high) begin
                        if (i_in.in_final) begin
                            cmd.has_main = 1'b1;
                            cmd.main_cp  = {5'd0, unit};
                        end else begin
                            n_held      = 1'b1;
                            n_held_bits = unit[9:0];
                        end
                    end else if (unit != 16'd0) begin
                        cmd.has_main = 1'b1;
                        cmd.main_cp  = {5'd0, unit};
                    end
                end
            end
            if (i_in.in_final) begin
                n_odd_phase  = 1'b0;
                n_first_half = '0;
                n_held       = 1'b0;
                n_held_bits  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode  <= 1'b1;
            r_odd_phase  <= 1'b0;
            r_first_half <= '0;
            r_held       <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_wide_mode  <= n_wide_mode;
            r_odd_phase  <= n_odd_phase;
            r_first_half <= n_first_half;
            r_held       <= n_held;
            r_held_bits  <= n_held_bits;
        end
    end

    assign o_full     = i_cmd_full;
    assign o_cmd_push = accept && (cmd.has_held || cmd.has_main);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> rtl/u16u8_queue.sv
`default_nettype none

module u16u8_queue
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty
);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

>>> rtl/u16u8_back.sv
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_head,
    input  wire logic i_q_empty,
    output logic      o_q_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic       r_on_main, n_on_main;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;

    logic        sel_main;
    logic [20:0] cur_cp;
    logic        cur_raw;
    logic [2:0]  cur_len;
    logic [7:0]  cur_byte;
    logic        last_in_part;
    logic        last_in_cmd;
    logic        advance;

    assign sel_main     = r_on_main || !i_head.has_held;
    assign cur_cp       = sel_main ? i_head.main_cp
                                   : {5'd0, SURR_HI_TAG, i_head.held_bits};
    assign cur_raw      = sel_main && i_head.main_raw;
    assign cur_len      = cur_raw ? 3'd1 : utf8_len(cur_cp);
    assign cur_byte     = cur_raw ? cur_cp[7:0] : utf8_byte(cur_cp, cur_len, r_idx);
    assign last_in_part = ({1'b0, r_idx} == (cur_len - 3'd1));
    assign last_in_cmd  = last_in_part && (sel_main || !i_head.has_main);
    assign advance      = !i_q_empty && (!r_out_valid || i_pop);

    always_comb begin
        n_on_main   = r_on_main;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
            if (last_in_part) begin
                n_idx     = '0;
                n_on_main = !last_in_cmd;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_main   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_on_main   <= n_on_main;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.out_byte    <= cur_byte;
            r_out.out_run_end <= last_in_cmd;
        end
    end

    assign o_q_pop = advance && last_in_cmd;
    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> ({1'b0, r_idx} < cur_len))
        else $error("byte index past end of sequence");

    a_main_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_on_main |-> (!i_q_empty && i_head.has_main))
        else $error("main part selected without a queued main part");

endmodule

`default_nettype wire

>>> rtl/utf16be_to_utf8_transcoder.sv
`default_nettype none

// UTF-16BE to UTF-8 transcoder for name strings. Bytes enter one per item
// with a final flag; in wide mode (reset default) they pair big-endian into
// code units, surrogate pairs are joined, lone surrogates come out as 3-byte
// sequences, code point zero and an odd trailing byte are dropped, and a
// high surrogate still held at the final byte is flushed. In byte mode only
// printable bytes (0x20 and above, except 0x7F) pass unchanged. Every item
// that produces output yields 1 to 6 result items, the last of them with
// out_run_end set; all per-string state clears after the final byte. The
// front end takes one input item per cycle while its four-entry command
// queue has room; the back end serialises one UTF-8 byte per cycle while
// its output register is empty or being popped, so the output serialiser
// sets the sustained rate. The first byte of a result passes through the
// command queue and then the output register before it shows. Write
// wide_mode only while idle; the configuration channel is always ready.

module utf16be_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // input item queue side
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in,
    // result queue side
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_out,
    // configuration write channel
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic     i_cfg_wide_mode
);

    // front end to command queue
    logic cmd_push;
    t_cmd cmd;
    logic cmd_full;

    // command queue to back end
    t_cmd head;
    logic q_empty;
    logic q_pop;

    // Classify each item, track the surrogate state and queue a command.
    u16u8_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_in           (i_in),
        .o_full         (full),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_wide_mode(i_cfg_wide_mode),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd),
        .i_cmd_full     (cmd_full)
    );

    // Decouple classification from serialisation.
    u16u8_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_cmd  (cmd),
        .o_full (cmd_full),
        .i_pop  (q_pop),
        .o_head (head),
        .o_empty(q_empty)
    );

    // Encode one byte per cycle into the output register when it frees.
    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_empty(q_empty),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_out    (o_out)
    );

    // Hold the configuration channel open: the register is a single flop.
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
